// ===== hdl/gss_pkg.sv =====
// shared types and constants of the gyro stroke segmenter
package gss_pkg;

  localparam int MaxStrokes = 8;
  localparam int CountW     = 4;
  localparam int RateW      = 17;
  localparam int AccW       = 20;
  localparam int CfgW       = 16;
  localparam int ApbDataW   = 32;
  localparam int ApbAddrW   = 3;

  localparam logic signed [AccW-1:0] AccMax = {1'b0, {(AccW-1){1'b1}}};
  localparam logic signed [AccW-1:0] AccMin = {1'b1, {(AccW-1){1'b0}}};

  localparam logic [CfgW-1:0] StepSizeReset   = 16'd1024;
  localparam logic [CfgW-1:0] NoiseFloorReset = 16'd24;

  // register index, taken from paddr[2]
  localparam logic REG_STEP_SIZE   = 1'b0;
  localparam logic REG_NOISE_FLOOR = 1'b1;

  localparam logic OP_FEED  = 1'b0;
  localparam logic OP_CLEAR = 1'b1;

  typedef enum logic [1:0] {
    DIR_RIGHT = 2'd0,
    DIR_UP    = 2'd1,
    DIR_LEFT  = 2'd2,
    DIR_DOWN  = 2'd3
  } dir_t;

  typedef struct packed {
    logic signed [AccW-1:0] acc_horiz;
    logic signed [AccW-1:0] acc_vert;
    logic                   stroke_valid;
    dir_t                   current_dir;
    logic [CountW-1:0]      code_count;
    logic                   moved_flag;
  } state_t;

  typedef struct packed {
    logic              opcode;
    logic [RateW-1:0]  horiz_rate;
    logic [RateW-1:0]  vert_rate;
  } item_t;

  typedef struct packed {
    logic              committed;
    dir_t              direction;
    logic [CountW-1:0] stroke_count;
    logic              moved;
    logic              dropped;
  } result_t;

  typedef struct packed {
    logic [CfgW-1:0] step_size;
    logic [CfgW-1:0] noise_floor;
  } cfg_t;

endpackage

// ===== hdl/gss_step.sv =====
// next-state and result logic for one gyro sample
module gss_step (
  input  gss_pkg::state_t  st,
  input  gss_pkg::item_t   item,
  input  gss_pkg::cfg_t    cfg,
  output gss_pkg::state_t  st_next,
  output gss_pkg::result_t res
);
  import gss_pkg::*;

  function automatic logic [AccW-1:0] abs_acc(input logic [AccW-1:0] v);
    abs_acc = v[AccW-1] ? (~v + 1'b1) : v;
  endfunction

  function automatic logic [AccW-1:0] sat_acc(input logic [AccW:0] s);
    if (s[AccW] != s[AccW-1]) begin
      sat_acc = s[AccW] ? AccMin : AccMax;
    end else begin
      sat_acc = s[AccW-1:0];
    end
  endfunction

  logic [RateW-1:0]        mag_h;
  logic [RateW-1:0]        mag_v;
  logic [RateW:0]          mag;
  logic                    passes;
  logic [AccW:0]           sum_h;
  logic [AccW:0]           sum_v;
  logic [AccW-1:0]         acc_h;
  logic [AccW-1:0]         acc_v;
  logic [AccW-1:0]         abs_h;
  logic [AccW-1:0]         abs_v;
  logic [AccW:0]           l1;
  logic                    horiz;
  logic signed [AccW:0]    fwd;
  logic signed [AccW:0]    step_s;
  logic [AccW-1:0]         perp;
  logic [AccW-1:0]         abs_perp;
  logic [AccW-1:0]         twice_step;
  logic                    commit;
  logic                    extend;
  dir_t                    dir;

  always_comb begin
    mag_h  = item.horiz_rate[RateW-1] ? (~item.horiz_rate + 1'b1) : item.horiz_rate;
    mag_v  = item.vert_rate[RateW-1]  ? (~item.vert_rate + 1'b1)  : item.vert_rate;
    mag    = {1'b0, mag_h} + {1'b0, mag_v};
    passes = mag >= {{(RateW+1-CfgW){1'b0}}, cfg.noise_floor};

    // accumulate with saturation at the signed limits
    sum_h = {st.acc_horiz[AccW-1], st.acc_horiz}
          + {{(AccW+1-RateW){item.horiz_rate[RateW-1]}}, item.horiz_rate};
    sum_v = {st.acc_vert[AccW-1], st.acc_vert}
          + {{(AccW+1-RateW){item.vert_rate[RateW-1]}}, item.vert_rate};
    acc_h = sat_acc(sum_h);
    acc_v = sat_acc(sum_v);
    abs_h = abs_acc(acc_h);
    abs_v = abs_acc(acc_v);
    l1    = {1'b0, abs_h} + {1'b0, abs_v};

    horiz  = (st.current_dir == DIR_RIGHT) || (st.current_dir == DIR_LEFT);
    step_s = $signed({{(AccW+1-CfgW){1'b0}}, cfg.step_size});
    case (st.current_dir)
      DIR_RIGHT: fwd = $signed({acc_h[AccW-1], acc_h});
      DIR_UP:    fwd = $signed({acc_v[AccW-1], acc_v});
      DIR_LEFT:  fwd = -$signed({acc_h[AccW-1], acc_h});
      default:   fwd = -$signed({acc_v[AccW-1], acc_v});
    endcase
    perp       = horiz ? acc_v : acc_h;
    abs_perp   = abs_acc(perp);
    twice_step = {{(AccW-CfgW-1){1'b0}}, cfg.step_size, 1'b0};

    commit = 1'b0;
    extend = 1'b0;
    dir    = DIR_RIGHT;
    if (!st.stroke_valid) begin
      if (l1 >= {{(AccW+1-CfgW){1'b0}}, cfg.step_size}) begin
        commit = 1'b1;
        if (abs_h >= abs_v) begin
          dir = (!acc_h[AccW-1] && (|acc_h)) ? DIR_RIGHT : DIR_LEFT;
        end else begin
          dir = (!acc_v[AccW-1] && (|acc_v)) ? DIR_UP : DIR_DOWN;
        end
      end
    end else if (fwd >= step_s) begin
      extend = 1'b1;
    end else if (fwd <= -step_s) begin
      commit = 1'b1;
      dir    = dir_t'(st.current_dir + 2'd2);
    end else if (abs_perp >= twice_step) begin
      commit = 1'b1;
      if (horiz) begin
        dir = (!perp[AccW-1] && (|perp)) ? DIR_UP : DIR_DOWN;
      end else begin
        dir = (!perp[AccW-1] && (|perp)) ? DIR_RIGHT : DIR_LEFT;
      end
    end

    st_next = st;
    res     = '0;
    if (item.opcode == OP_CLEAR) begin
      st_next = '0;
    end else if (passes) begin
      st_next.moved_flag = 1'b1;
      st_next.acc_horiz  = acc_h;
      st_next.acc_vert   = acc_v;
      if (commit || extend) begin
        st_next.acc_horiz = '0;
        st_next.acc_vert  = '0;
      end
      if (commit) begin
        st_next.current_dir  = dir;
        st_next.stroke_valid = 1'b1;
        res.committed        = 1'b1;
        res.direction        = dir;
        if (st.code_count < CountW'(MaxStrokes)) begin
          st_next.code_count = st.code_count + 1'b1;
        end else begin
          res.dropped = 1'b1;
        end
      end
    end
    res.stroke_count = st_next.code_count;
    res.moved        = st_next.moved_flag;
  end

endmodule

// ===== hdl/gyro_stroke_segmenter_core.sv =====
// top level of the gyro stroke segmenter: channels, registers and state
// an accepted beat is registered in the input register, then in the result register, which presents it
// throughput: one beat per cycle while out_stall stays low; the accumulator state
// updates as a beat moves from the input register into the result register
// reset: rst is synchronous, active high; it empties both stages, clears the
// stroke state and restores step_size 1024 and noise_floor 24
module gyro_stroke_segmenter_core (
  input  logic                               clk,
  input  logic                               rst,
  // input channel
  input  logic                               in_valid,
  output logic                               in_stall,
  input  logic                               opcode,
  input  logic signed [gss_pkg::RateW-1:0]   horiz_rate,
  input  logic signed [gss_pkg::RateW-1:0]   vert_rate,
  // result channel
  output logic                               out_valid,
  input  logic                               out_stall,
  output logic                               committed,
  output logic [1:0]                         direction,
  output logic [gss_pkg::CountW-1:0]         stroke_count,
  output logic                               moved,
  output logic                               dropped,
  // configuration port
  input  logic                               psel,
  input  logic                               penable,
  input  logic                               pwrite,
  input  logic [gss_pkg::ApbAddrW-1:0]       paddr,
  input  logic [gss_pkg::ApbDataW-1:0]       pwdata,
  output logic [gss_pkg::ApbDataW-1:0]       prdata,
  output logic                               pready
);
  import gss_pkg::*;

  // configuration registers
  cfg_t    cfg;
  logic    cfg_write;

  // input register stage
  logic    s1_valid;
  item_t   s1_item;
  logic    s1_take;
  logic    in_accept;

  // stroke state and the result register
  state_t  st;
  state_t  st_next;
  result_t res_next;
  result_t res;

  // ---------------------------------------------------------------------------
  // configuration port: zero wait states, byte lane bits of paddr ignored
  // ---------------------------------------------------------------------------
  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.step_size   <= StepSizeReset;
      cfg.noise_floor <= NoiseFloorReset;
    end else if (cfg_write) begin
      unique case (paddr[2])
        REG_STEP_SIZE:   cfg.step_size   <= pwdata[CfgW-1:0];
        REG_NOISE_FLOOR: cfg.noise_floor <= pwdata[CfgW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[2])
      REG_STEP_SIZE:   prdata = {{(ApbDataW-CfgW){1'b0}}, cfg.step_size};
      REG_NOISE_FLOOR: prdata = {{(ApbDataW-CfgW){1'b0}}, cfg.noise_floor};
      default:         prdata = '0;
    endcase
  end

  // ---------------------------------------------------------------------------
  // handshake: the input register empties into the result register whenever
  // that register is empty or being taken this cycle, so a result being taken
  // does not block the next beat from landing in the input register
  // ---------------------------------------------------------------------------
  assign s1_take   = s1_valid && (!out_valid || !out_stall);
  assign in_stall  = s1_valid && !s1_take;
  assign in_accept = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (!in_stall) begin
      s1_valid <= in_valid;
    end
  end

  // payload holds no reset
  always_ff @(posedge clk) begin
    if (in_accept) begin
      s1_item.opcode     <= opcode;
      s1_item.horiz_rate <= horiz_rate;
      s1_item.vert_rate  <= vert_rate;
    end
  end

  // ---------------------------------------------------------------------------
  // per-sample logic: clear, noise gate, saturating accumulate, commit decision
  // ---------------------------------------------------------------------------
  gss_step u_step (
    .st      (st),
    .item    (s1_item),
    .cfg     (cfg),
    .st_next (st_next),
    .res     (res_next)
  );

  // stroke state advances exactly once per beat, when it leaves the input stage
  always_ff @(posedge clk) begin
    if (rst) begin
      st <= '0;
    end else if (s1_take) begin
      st <= st_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (!out_valid || !out_stall) begin
      out_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_take) begin
      res <= res_next;
    end
  end

  assign committed    = res.committed;
  assign direction    = res.direction;
  assign stroke_count = res.stroke_count;
  assign moved        = res.moved;
  assign dropped      = res.dropped;

  // ---------------------------------------------------------------------------
  // checks
  // ---------------------------------------------------------------------------
  // a dropped code is always a commit
  a_drop_is_commit: assert property (@(posedge clk) disable iff (rst)
    out_valid && dropped |-> committed)
    else $error("dropped without commit");

  // a commit means the sample passed the floor
  a_commit_moved: assert property (@(posedge clk) disable iff (rst)
    out_valid && committed |-> moved)
    else $error("commit without motion");

  // direction reads zero when nothing committed
  a_dir_quiet: assert property (@(posedge clk) disable iff (rst)
    out_valid && !committed |-> (direction == DIR_RIGHT))
    else $error("direction set without commit");

  // a commit leaves a live stroke behind it
  a_commit_sets_stroke: assert property (@(posedge clk) disable iff (rst)
    s1_take && res_next.committed |=> st.stroke_valid)
    else $error("commit did not set stroke");

  // the buffer count never passes its cap
  a_count_cap: assert property (@(posedge clk) disable iff (rst)
    st.code_count <= CountW'(MaxStrokes))
    else $error("code count over capacity");

endmodule

// ===== sim/gss_checker.sv =====
// scoreboard for the gyro stroke segmenter: predicts every result beat and compares it
module gss_checker
  import gss_pkg::*;
(
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       in_valid,
  input  logic                       in_stall,
  input  logic                       opcode,
  input  logic signed [RateW-1:0]    horiz_rate,
  input  logic signed [RateW-1:0]    vert_rate,
  input  logic                       out_valid,
  input  logic                       out_stall,
  input  logic                       committed,
  input  logic [1:0]                 direction,
  input  logic [CountW-1:0]          stroke_count,
  input  logic                       moved,
  input  logic                       dropped,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic                       pready,
  input  logic [ApbAddrW-1:0]        paddr,
  input  logic [ApbDataW-1:0]        pwdata,
  output int                         mismatches,
  output int                         reports_due
);
  timeunit 1ns;
  timeprecision 1ps;

  logic [CfgW-1:0]        step_q;
  logic [CfgW-1:0]        floor_q;
  logic signed [AccW-1:0] sum_h;
  logic signed [AccW-1:0] sum_v;
  logic                   on_stroke;
  dir_t                   heading;
  logic [CountW-1:0]      n_codes;
  logic                   any_motion;
  result_t                stroke_reports[$];

  function automatic int mag(input int v);
    return (v < 0) ? -v : v;
  endfunction

  function automatic logic signed [AccW-1:0] clamp_acc(input int v);
    if (v > int'(AccMax)) return AccMax;
    if (v < int'(AccMin)) return AccMin;
    return v[AccW-1:0];
  endfunction

  task automatic log_mismatch(input string msg);
    mismatches++;
    $display("%0t: %s", $time, msg);
  endtask

  // one sample through the segmenter state, giving the result it reports
  task automatic segment_sample(input logic op, input logic signed [RateW-1:0] hr,
                                input logic signed [RateW-1:0] vr, output result_t r);
    int   gx, gy, ih, iv, stp, fwd, perp;
    logic hit;
    logic horiz;
    dir_t d;
    r   = '0;
    hit = 1'b0;
    d   = DIR_RIGHT;
    if (op == OP_CLEAR) begin
      sum_h      = '0;
      sum_v      = '0;
      on_stroke  = 1'b0;
      heading    = DIR_RIGHT;
      n_codes    = '0;
      any_motion = 1'b0;
    end else begin
      gx  = hr;
      gy  = vr;
      stp = int'(step_q);
      if (mag(gx) + mag(gy) >= int'(floor_q)) begin
        any_motion = 1'b1;
        sum_h = clamp_acc(int'(sum_h) + gx);
        sum_v = clamp_acc(int'(sum_v) + gy);
        ih = sum_h;
        iv = sum_v;
        if (!on_stroke) begin
          if (mag(ih) + mag(iv) >= stp) begin
            hit = 1'b1;
            if (mag(ih) >= mag(iv)) d = (ih > 0) ? DIR_RIGHT : DIR_LEFT;
            else d = (iv > 0) ? DIR_UP : DIR_DOWN;
          end
        end else begin
          horiz = (heading == DIR_RIGHT) || (heading == DIR_LEFT);
          perp  = horiz ? iv : ih;
          case (heading)
            DIR_RIGHT: fwd = ih;
            DIR_UP:    fwd = iv;
            DIR_LEFT:  fwd = -ih;
            default:   fwd = -iv;
          endcase
          if (fwd >= stp) begin
            sum_h = '0;
            sum_v = '0;
          end else if (fwd <= -stp) begin
            hit = 1'b1;
            d   = dir_t'(heading + 2'd2);
          end else if (mag(perp) >= 2 * stp) begin
            hit = 1'b1;
            if (horiz) d = (perp > 0) ? DIR_UP : DIR_DOWN;
            else d = (perp > 0) ? DIR_RIGHT : DIR_LEFT;
          end
        end
        if (hit) begin
          heading   = d;
          on_stroke = 1'b1;
          sum_h     = '0;
          sum_v     = '0;
          if (n_codes < MaxStrokes) n_codes++;
          else r.dropped = 1'b1;
        end
      end
    end
    r.committed    = hit;
    r.direction    = hit ? d : DIR_RIGHT;
    r.stroke_count = n_codes;
    r.moved        = any_motion;
  endtask

  always @(posedge clk) begin
    result_t want;
    if (rst) begin
      step_q      = StepSizeReset;
      floor_q     = NoiseFloorReset;
      sum_h       = '0;
      sum_v       = '0;
      on_stroke   = 1'b0;
      heading     = DIR_RIGHT;
      n_codes     = '0;
      any_motion  = 1'b0;
      stroke_reports.delete();
      reports_due = 0;
      mismatches  = 0;
    end else begin
      if (psel && penable && pwrite && pready) begin
        if (paddr[2] == REG_STEP_SIZE) step_q = pwdata[CfgW-1:0];
        else if (paddr[2] == REG_NOISE_FLOOR) floor_q = pwdata[CfgW-1:0];
      end
      if (out_valid && !out_stall) begin
        if (stroke_reports.size() == 0) begin
          log_mismatch("result beat with no sample waiting for it");
        end else begin
          want = stroke_reports.pop_front();
          if (committed !== want.committed)
            log_mismatch($sformatf("committed %0b, expected %0b", committed, want.committed));
          if (direction !== want.direction)
            log_mismatch($sformatf("direction %0d, expected %0d", direction, want.direction));
          if (stroke_count !== want.stroke_count)
            log_mismatch($sformatf("stroke_count %0d, expected %0d", stroke_count,
                                   want.stroke_count));
          if (moved !== want.moved)
            log_mismatch($sformatf("moved %0b, expected %0b", moved, want.moved));
          if (dropped !== want.dropped)
            log_mismatch($sformatf("dropped %0b, expected %0b", dropped, want.dropped));
        end
      end
      if (in_valid && !in_stall) begin
        segment_sample(opcode, horiz_rate, vert_rate, want);
        stroke_reports.push_back(want);
      end
      reports_due = stroke_reports.size();
    end
  end

endmodule

// ===== sim/tb.sv =====
// testbench top for the gyro stroke segmenter: clock, reset, stimulus and verdict
module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import gss_pkg::*;

  logic                clk        = 1'b0;
  logic                rst        = 1'b1;
  logic                in_valid   = 1'b0;
  logic                in_stall;
  logic                opcode     = OP_FEED;
  logic [RateW-1:0]    horiz_rate = '0;
  logic [RateW-1:0]    vert_rate  = '0;
  logic                out_valid;
  logic                out_stall  = 1'b0;
  logic                committed;
  logic [1:0]          direction;
  logic [CountW-1:0]   stroke_count;
  logic                moved;
  logic                dropped;
  logic                psel       = 1'b0;
  logic                penable    = 1'b0;
  logic                pwrite     = 1'b0;
  logic [ApbAddrW-1:0] paddr      = '0;
  logic [ApbDataW-1:0] pwdata     = '0;
  logic [ApbDataW-1:0] prdata;
  logic                pready;

  int mismatches;
  int reports_due;

  // current register settings, used to scale the stroke stimulus
  int cur_step  = 1024;
  int cur_floor = 24;
  // sender runs gap-free while set
  bit tx_steady = 1'b0;
  // cycles the receiver must hold off before its next beat
  int rx_hold   = 0;

  gyro_stroke_segmenter_core u_top (.*);
  gss_checker u_chk (.*);

  always #5 clk = ~clk;

  // safety net against a hung handshake or a lost result
  initial begin
    #3000000;
    $display("[FAIL] regression broken");
    $finish;
  end

  // one beat on the sample channel; called and returns at a falling edge
  task automatic send_beat(input logic op, input logic [RateW-1:0] h,
                           input logic [RateW-1:0] v);
    int gap;
    gap = tx_steady ? 0 : $urandom_range(0, 7);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    opcode     <= op;
    horiz_rate <= h;
    vert_rate  <= v;
    in_valid   <= 1'b1;
    do @(posedge clk); while (in_stall);
    @(negedge clk);
  endtask

  // setup then access cycle; psel is left high so writes can chain
  task automatic write_reg(input logic idx, input logic [CfgW-1:0] val);
    logic [ApbDataW-1:0] bus;
    bus           = $urandom();
    bus[CfgW-1:0] = val;   // upper bits are junk the register must ignore
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= bus;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    @(negedge clk);
  endtask

  // stop offering samples and wait for every predicted result to come back
  task automatic drain();
    in_valid <= 1'b0;
    while (reports_due != 0) @(negedge clk);
  endtask

  task automatic apply_setting(input int s, input int f);
    drain();
    write_reg(REG_STEP_SIZE, s[CfgW-1:0]);
    write_reg(REG_NOISE_FLOOR, f[CfgW-1:0]);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    cur_step  = s;
    cur_floor = f;
  endtask

  // one sample moving mostly along d, sized against step and floor
  task automatic stroke_beat(input dir_t d);
    int along, across, back;
    along = cur_step / 3 + 1 + $urandom_range(0, cur_step / 2 + 1);
    if (along < cur_floor) along = cur_floor + $urandom_range(0, 16);
    if (along > 65535) along = 65535;
    across = $urandom_range(0, along / 4);
    if ($urandom_range(0, 1)) across = -across;
    back = -along;
    case (d)
      DIR_RIGHT: send_beat(OP_FEED, along[RateW-1:0], across[RateW-1:0]);
      DIR_UP:    send_beat(OP_FEED, across[RateW-1:0], along[RateW-1:0]);
      DIR_LEFT:  send_beat(OP_FEED, back[RateW-1:0], across[RateW-1:0]);
      default:   send_beat(OP_FEED, across[RateW-1:0], back[RateW-1:0]);
    endcase
  endtask

  // mostly runs of same-direction samples, which drive commits, extensions,
  // reversals and turns; the rest is raw noise, floor-edge samples and clears
  task automatic run_phase(input int n_items, input bit squeeze);
    int          sent, k, burst_left, l1, hp, vp;
    logic [31:0] h, v;
    dir_t        d;
    sent       = 0;
    burst_left = 0;
    if (squeeze) begin
      // receiver sits out a long stretch while samples keep coming
      rx_hold    = 80;
      tx_steady  = 1'b1;
      burst_left = 60;
    end
    while (sent < n_items) begin
      if (burst_left <= 0) begin
        tx_steady  = ($urandom_range(0, 3) == 0);
        burst_left = 40;
      end
      case ($urandom_range(0, 9))
        0: begin
          // anything the 17-bit fields can carry, out-of-range rates too
          h = $urandom();
          v = $urandom();
          send_beat(($urandom_range(0, 7) == 0) ? OP_CLEAR : OP_FEED,
                    h[RateW-1:0], v[RateW-1:0]);
          k = 1;
        end
        1: begin
          // l1 magnitude one below, at, or one above the floor
          l1 = cur_floor - 1 + $urandom_range(0, 2);
          if (l1 < 0) l1 = 0;
          hp = $urandom_range(0, (l1 > 65535) ? 65535 : l1);
          vp = l1 - hp;
          if (vp > 65535) vp = 65535;
          if ($urandom_range(0, 1)) hp = -hp;
          if ($urandom_range(0, 1)) vp = -vp;
          send_beat(OP_FEED, hp[RateW-1:0], vp[RateW-1:0]);
          k = 1;
        end
        default: begin
          d = dir_t'($urandom_range(0, 3));
          k = $urandom_range(1, 6);
          repeat (k) stroke_beat(d);
        end
      endcase
      // occasional window clear so the code buffer both fills and empties
      if ($urandom_range(0, 19) == 0) begin
        h = $urandom();
        v = $urandom();
        send_beat(OP_CLEAR, h[RateW-1:0], v[RateW-1:0]);
        k++;
      end
      sent       += k;
      burst_left -= k;
    end
  endtask

  // result side: random hold-off per beat, in runs, plus the long hold
  initial begin
    int gap, run;
    bit rx_steady;
    run       = 0;
    rx_steady = 1'b0;
    wait (rst == 1'b0);
    @(negedge clk);
    forever begin
      if (run == 0) begin
        rx_steady = ($urandom_range(0, 3) == 0);
        run       = 40;
      end
      run--;
      gap = rx_steady ? 0 : $urandom_range(0, 7);
      if (rx_hold > 0) begin
        gap     += rx_hold;
        rx_hold  = 0;
      end
      if (gap > 0) begin
        out_stall <= 1'b1;
        repeat (gap) @(negedge clk);
      end
      out_stall <= 1'b0;
      do @(posedge clk); while (!out_valid);
      @(negedge clk);
    end
  end

  initial begin
    int ph;
    repeat (7) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // directed walk at the reset settings (step 1024, floor 24)
    send_beat(OP_CLEAR, 17'h1FFFF, 17'h1FFFF);    // clear ignores its rates
    send_beat(OP_FEED, 17'sd0, 17'sd0);           // quiet sample
    send_beat(OP_FEED, 17'sd12, -17'sd11);        // one below the floor
    send_beat(OP_FEED, 17'sd12, -17'sd12);        // exactly at the floor
    send_beat(OP_FEED, 17'sd1012, 17'sd0);        // first stroke, right
    send_beat(OP_FEED, 17'sd1024, 17'sd5);        // extend
    send_beat(OP_FEED, -17'sd1024, 17'sd0);       // reversal to left
    send_beat(OP_FEED, 17'sd0, 17'sd2048);        // turn up
    send_beat(OP_FEED, 17'sd0, -17'sd1024);       // reversal to down
    send_beat(OP_FEED, -17'sd2048, 17'sd0);       // turn from vertical to left
    send_beat(OP_CLEAR, 17'h0, 17'h0);
    send_beat(OP_FEED, 17'sd600, -17'sd600);      // tie goes horizontal, right
    send_beat(OP_CLEAR, 17'h0, 17'h0);
    send_beat(OP_FEED, -17'sd600, 17'sd600);      // negative tie, left
    send_beat(OP_CLEAR, 17'h0, 17'h0);
    send_beat(OP_FEED, 17'h0FFFF, 17'h0FFFF);     // largest positive rates
    send_beat(OP_FEED, 17'h10000, 17'h10000);     // most negative rates
    // bounce left and right until the buffer is full and a commit drops
    for (int i = 0; i < 7; i++)
      send_beat(OP_FEED, (i % 2 == 0) ? 17'sd2000 : -17'sd2000, 17'sd0);

    for (ph = 0; ph < 8; ph++) begin
      case (ph)
        0: apply_setting(1024, 24);
        1: apply_setting(1, 0);
        2: apply_setting(65535, 65535);
        3: apply_setting(0, 0);         // every passing sample commits or extends
        4: apply_setting(64, 8);
        5: apply_setting(300, 100);
        6: apply_setting(16, 65535);
        default: apply_setting(2000, 500);
      endcase
      run_phase(240, (ph == 2) || (ph == 5));
    end

    drain();
    repeat (4) @(negedge clk);   // pipeline is two deep; catch any stray beat
    if (mismatches == 0)
      $display("[ OK ] regression clean");
    else
      $display("[FAIL] regression broken");
    $finish;
  end

endmodule

// ===== gyro_stroke_segmenter_core.f =====
hdl/gss_pkg.sv
hdl/gss_step.sv
hdl/gyro_stroke_segmenter_core.sv
sim/gss_checker.sv
sim/tb.sv
